### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising edge, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

### design/scta_pkg.sv
// types, codes and key tables of the scan code translator
`default_nettype none

package scta_pkg;

	// request opcodes
	localparam logic [1:0] OP_SCAN  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	// set 1 scan codes with a special meaning
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_CAPS       = 8'h3A;

	// bit position of the break flag
	localparam int BREAK_BIT = 7;

	// number of make codes covered by the tables
	localparam logic [7:0] TABLE_LEN = 8'd58;

	typedef logic [6:0] char_t;
	typedef char_t key_tab_t [0:57];

	// unshifted characters
	localparam key_tab_t PLAIN_TAB = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	// characters with shift held
	localparam key_tab_t SHIFT_TAB = '{
		7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	// caps lock: letters upper case, everything else as unshifted
	function automatic char_t caps_char(input logic [5:0] idx);
		char_t plain;
		plain = PLAIN_TAB[idx];
		if (plain >= 7'h61 && plain <= 7'h7A) begin
			return SHIFT_TAB[idx];
		end
		return plain;
	endfunction

	// character headed for the buffer
	typedef struct packed {
		logic  push;
		char_t ch;
	} push_req_t;

	// per-request buffer outcome
	typedef struct packed {
		logic popped;
		logic has_char;
		logic dropped;
	} fifo_stat_t;

endpackage

`default_nettype wire

### design/scancode_to_ascii_with_fifo_unit.sv
// set 1 scan code translator with a character buffer, top level
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+------------------------------------
//  in      | into unit | in_valid/in_stall  | op, scan_byte
//  out     | from unit | out_valid/out_stall| char_valid, char_out, has_char, dropped
//
// one result per request, registered in the input and then the result register; one
// request per cycle while out_stall is low; rate is set by the single pass from input
// register through translation and buffer pointer update to the result register
// buffer read data comes from a registered port of the character memory
// arst_n clears modifier flags, pointers and valids; buffer contents are not cleared
// a stalled result holds the input register, which then stalls the input side
`default_nettype none

module scancode_to_ascii_with_fifo_unit #(
	parameter int BUFFER_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  scan_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             char_valid,
	output logic [6:0]       char_out,
	output logic             has_char,
	output logic             dropped
);

	logic                    valid_s1;
	logic [1:0]              op_s1;
	logic [7:0]              scan_s1;
	logic                    valid_s2;
	logic                    char_valid_s2;
	logic                    has_char_s2;
	logic                    dropped_s2;
	logic                    adv;
	logic                    in_acc;
	scta_pkg::push_req_t     req;
	scta_pkg::fifo_stat_t    stat;
	scta_pkg::char_t         rd_data;

	// pipeline flow
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op;
			scan_s1 <= scan_byte;
		end
	end

	// translation and modifier flags
	scta_xlate u_xlate (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv && (op_s1 == scta_pkg::OP_SCAN)),
		.scan_byte (scan_s1),
		.req       (req)
	);

	// character buffer
	scta_fifo #(
		.DEPTH (BUFFER_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.req       (req),
		.pop       (op_s1 == scta_pkg::OP_READ),
		.flush     (op_s1 == scta_pkg::OP_FLUSH),
		.stat      (stat),
		.rd_data_q (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_valid_s2 <= stat.popped;
			has_char_s2   <= stat.has_char;
			dropped_s2    <= stat.dropped;
		end
	end

	assign out_valid  = valid_s2;
	assign char_valid = char_valid_s2;
	assign char_out   = char_valid_s2 ? rd_data : '0;
	assign has_char   = has_char_s2;
	assign dropped    = dropped_s2;

endmodule

`default_nettype wire

### design/scta_xlate.sv
// modifier state and scan code to character translation
`default_nettype none

module scta_xlate (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          scan_byte,
	output scta_pkg::push_req_t      req
);

	logic                shift_q;
	logic                caps_q;
	logic                shift_set;
	logic                shift_clr;
	logic                caps_tgl;
	logic                in_table;
	logic [5:0]          idx;
	scta_pkg::char_t     ch;

	// decode of the special codes
	always_comb begin
		shift_set = 1'b0;
		shift_clr = 1'b0;
		caps_tgl  = 1'b0;
		unique case (scan_byte) inside
			scta_pkg::SC_LSHIFT, scta_pkg::SC_RSHIFT:         shift_set = 1'b1;
			scta_pkg::SC_LSHIFT_BRK, scta_pkg::SC_RSHIFT_BRK: shift_clr = 1'b1;
			scta_pkg::SC_CAPS:                                caps_tgl  = 1'b1;
			default: ;
		endcase
	end

	// table lookup for plain make codes
	assign idx      = scan_byte[5:0];
	assign in_table = !scan_byte[scta_pkg::BREAK_BIT] && (scan_byte < scta_pkg::TABLE_LEN)
		&& !shift_set;

	always_comb begin
		if (caps_q) begin
			ch = scta_pkg::caps_char(idx);
		end else if (shift_q) begin
			ch = scta_pkg::SHIFT_TAB[idx];
		end else begin
			ch = scta_pkg::PLAIN_TAB[idx];
		end
	end

	assign req.push = step && in_table && (ch != '0);
	assign req.ch   = ch;

	// shift and caps lock flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (step) begin
			if (shift_set) begin
				shift_q <= 1'b1;
			end else if (shift_clr) begin
				shift_q <= 1'b0;
			end
			if (caps_tgl) begin
				caps_q <= !caps_q;
			end
		end
	end

endmodule

`default_nettype wire

### design/scta_fifo.sv
// ring buffer of characters with pop and flush
`default_nettype none

module scta_fifo #(
	parameter int DEPTH = 128
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire scta_pkg::push_req_t  req,
	input  wire logic                 pop,
	input  wire logic                 flush,
	output scta_pkg::fifo_stat_t      stat,
	output scta_pkg::char_t           rd_data_q
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	scta_pkg::char_t     mem [0:DEPTH-1];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [PTR_W-1:0]    wr_inc;
	logic [PTR_W-1:0]    rd_inc;
	logic [PTR_W-1:0]    wr_n;
	logic [PTR_W-1:0]    rd_n;
	logic                full;
	logic                empty;
	logic                do_push;
	logic                do_pop;

	// pointer arithmetic, one slot always kept free
	assign wr_inc  = (wr_q == LAST) ? '0 : wr_q + 1'b1;
	assign rd_inc  = (rd_q == LAST) ? '0 : rd_q + 1'b1;
	assign full    = (wr_inc == rd_q);
	assign empty   = (rd_q == wr_q);
	assign do_push = req.push && !full;
	assign do_pop  = en && pop && !empty;

	assign wr_n = do_push ? wr_inc : wr_q;
	assign rd_n = (en && flush) ? wr_q : (do_pop ? rd_inc : rd_q);

	assign stat.popped   = do_pop;
	assign stat.dropped  = req.push && full;
	assign stat.has_char = (rd_n != wr_n);

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (en) begin
			wr_q <= wr_n;
			rd_q <= rd_n;
		end
	end

	// character storage with registered read
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= req.ch;
		end
		if (en) begin
			rd_data_q <= mem[rd_q];
		end
	end

endmodule

`default_nettype wire

### design/scta_checker.sv
// port level checks of the scan code translator
`default_nettype none
`include "assert_macros.svh"

module scta_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        char_valid,
	input wire logic [6:0]  char_out,
	input wire logic        has_char,
	input wire logic        dropped
);

	logic [9:0] out_fields;

	// all result fields side by side
	assign out_fields = {char_valid, char_out, has_char, dropped};

	// a stalled result stays offered
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid)

	// a stalled result keeps its fields
	`ASSERT_CLK(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(out_fields))

	// no character shown without a pop
	`ASSERT_CLK(a_char_zero, clk, arst_n, out_valid && !char_valid |-> char_out == 7'd0)

	// a pop and a drop never come from the same request
	`ASSERT_NEVER(a_pop_drop, clk, arst_n, out_valid && char_valid && dropped)

	// a drop means the buffer is full, so it holds characters
	`ASSERT_CLK(a_drop_full, clk, arst_n, out_valid && dropped |-> has_char)

endmodule

bind scancode_to_ascii_with_fifo_unit scta_checker u_checker (.*);

`default_nettype wire
